>>> sv/mge_pkg.sv
// shared types and constants for the min-id group leader election block
// no dependencies; used by the interfaces, the register file and the core

package mge_pkg;

    // field widths
    localparam int ADDR_W   = 8;
    localparam int TIME_W   = 32;
    localparam int GID_W    = 16;
    localparam int SEQ_W    = 16;
    localparam int IVL_W    = 16;
    localparam int FACTOR_W = 8;
    localparam int SPAN_W   = IVL_W + FACTOR_W;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 3;
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;

    // default member map depth
    localparam int NODE_COUNT_DEF = 256;

    // reset values
    localparam logic [GID_W-1:0]    INITIAL_GROUP_ID   = 16'd257;
    localparam logic [ADDR_W-1:0]   OWN_ADDRESS_RST    = 8'd0;
    localparam logic [TIME_W-1:0]   ACC_EXPIRY_RST     = 32'd10;
    localparam logic [IVL_W-1:0]    HB_INTERVAL_RST    = 16'd5;
    localparam logic [FACTOR_W-1:0] TIMEOUT_FACTOR_RST = 8'd3;

    typedef enum logic [CMD_W-1:0] {
        CMD_START  = 2'd0,
        CMD_REPORT = 2'd1,
        CMD_FINISH = 2'd2,
        CMD_PACKET = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_NONE      = 3'd0,
        ST_SELF      = 3'd1,
        ST_NONMEMBER = 3'd2,
        ST_FORWARDED = 3'd3,
        ST_TAKEN     = 3'd4,
        ST_HIGHER    = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        REG_OWN_ADDRESS        = 2'd0,
        REG_ACCEPTABLE_EXPIRY  = 2'd1,
        REG_HEARTBEAT_INTERVAL = 2'd2,
        REG_TIMEOUT_FACTOR     = 2'd3
    } reg_index_t;

    // configuration as seen by the core
    typedef struct packed {
        logic [ADDR_W-1:0] own_address;
        logic [TIME_W-1:0] acceptable_expiry;
        logic [SPAN_W-1:0] timeout_span;
    } cfg_t;

endpackage

>>> sv/mge_if.sv
// valid/ready channel interfaces for input items and result items
// depends on mge_pkg for field widths

interface mge_item_if;
    logic                          valid;
    logic                          ready;
    logic [mge_pkg::CMD_W-1:0]     command;
    logic [mge_pkg::ADDR_W-1:0]    node_address;
    logic [mge_pkg::TIME_W-1:0]    link_expiry;
    logic [mge_pkg::GID_W-1:0]     packet_gid;
    logic [mge_pkg::SEQ_W-1:0]     packet_seqno;
    logic [mge_pkg::TIME_W-1:0]    now_seconds;

    modport source (
        output valid, command, node_address, link_expiry, packet_gid, packet_seqno,
               now_seconds,
        input  ready
    );
    modport sink (
        input  valid, command, node_address, link_expiry, packet_gid, packet_seqno,
               now_seconds,
        output ready
    );
endinterface

interface mge_result_if;
    logic                          valid;
    logic                          ready;
    logic                          send_valid;
    logic [mge_pkg::GID_W-1:0]     send_gid;
    logic [mge_pkg::SEQ_W-1:0]     send_seqno;
    logic                          send_repeat;
    logic [mge_pkg::STATUS_W-1:0]  packet_status;
    logic [mge_pkg::GID_W-1:0]     current_gid;

    modport source (
        output valid, send_valid, send_gid, send_seqno, send_repeat, packet_status,
               current_gid,
        input  ready
    );
    modport sink (
        input  valid, send_valid, send_gid, send_seqno, send_repeat, packet_status,
               current_gid,
        output ready
    );
endinterface

>>> sv/mge_cfg.sv
// configuration registers behind an apb-style port
// depends on mge_pkg; also precomputes the heartbeat timeout span

module mge_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mge_pkg::PADDR_W-1:0]   paddr,
    input  logic [mge_pkg::PDATA_W-1:0]   pwdata,
    output logic [mge_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output mge_pkg::cfg_t                 cfg
);

    logic [mge_pkg::ADDR_W-1:0]   own_address_reg;
    logic [mge_pkg::TIME_W-1:0]   acc_expiry_reg;
    logic [mge_pkg::IVL_W-1:0]    hb_interval_reg;
    logic [mge_pkg::FACTOR_W-1:0] timeout_factor_reg;
    logic [mge_pkg::SPAN_W-1:0]   span_reg;
    logic                         wr_en;
    mge_pkg::reg_index_t          reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = mge_pkg::reg_index_t'(paddr[3:2]);

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_address_reg    <= mge_pkg::OWN_ADDRESS_RST;
            acc_expiry_reg     <= mge_pkg::ACC_EXPIRY_RST;
            hb_interval_reg    <= mge_pkg::HB_INTERVAL_RST;
            timeout_factor_reg <= mge_pkg::TIMEOUT_FACTOR_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                mge_pkg::REG_OWN_ADDRESS:
                    own_address_reg <= pwdata[mge_pkg::ADDR_W-1:0];
                mge_pkg::REG_ACCEPTABLE_EXPIRY:
                    acc_expiry_reg <= pwdata[mge_pkg::TIME_W-1:0];
                mge_pkg::REG_HEARTBEAT_INTERVAL:
                    hb_interval_reg <= pwdata[mge_pkg::IVL_W-1:0];
                mge_pkg::REG_TIMEOUT_FACTOR:
                    timeout_factor_reg <= pwdata[mge_pkg::FACTOR_W-1:0];
            endcase
        end
    end

    // timeout span, registered from the heartbeat interval and timeout factor registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            span_reg <= mge_pkg::SPAN_W'(mge_pkg::TIMEOUT_FACTOR_RST)
                        * mge_pkg::SPAN_W'(mge_pkg::HB_INTERVAL_RST);
        end
        else
        begin
            span_reg <= mge_pkg::SPAN_W'(timeout_factor_reg)
                        * mge_pkg::SPAN_W'(hb_interval_reg);
        end
    end

    // read mux
    always_comb
    begin
        unique case (reg_sel)
            mge_pkg::REG_OWN_ADDRESS:
                prdata = mge_pkg::PDATA_W'(own_address_reg);
            mge_pkg::REG_ACCEPTABLE_EXPIRY:
                prdata = mge_pkg::PDATA_W'(acc_expiry_reg);
            mge_pkg::REG_HEARTBEAT_INTERVAL:
                prdata = mge_pkg::PDATA_W'(hb_interval_reg);
            mge_pkg::REG_TIMEOUT_FACTOR:
                prdata = mge_pkg::PDATA_W'(timeout_factor_reg);
        endcase
    end

    assign cfg.own_address       = own_address_reg;
    assign cfg.acceptable_expiry = acc_expiry_reg;
    assign cfg.timeout_span      = span_reg;

endmodule

>>> sv/mge_core.sv
// election core: input register, one pass of update logic, result register
// depends on mge_pkg and the channel interfaces in mge_if

module mge_core #(
    parameter int NODE_COUNT = mge_pkg::NODE_COUNT_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mge_pkg::cfg_t        cfg,
    mge_item_if.sink             item,
    mge_result_if.source         result
);

    localparam int IDX_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int CMP_W = mge_pkg::ADDR_W + 1;

    // input register
    logic                         hold_valid_reg;
    mge_pkg::cmd_t                cmd_reg;
    logic [mge_pkg::ADDR_W-1:0]   addr_reg;
    logic [mge_pkg::TIME_W-1:0]   expiry_reg;
    logic [mge_pkg::GID_W-1:0]    pgid_reg;
    logic [mge_pkg::SEQ_W-1:0]    pseq_reg;
    logic [mge_pkg::TIME_W-1:0]   now_reg;

    // election state
    logic [NODE_COUNT-1:0]        member_reg, member_next;
    logic [mge_pkg::ADDR_W-1:0]   least_reg, least_next;
    logic [mge_pkg::GID_W-1:0]    gid_reg, gid_next;
    logic [mge_pkg::SEQ_W-1:0]    gseq_reg, gseq_next;
    logic [mge_pkg::SEQ_W-1:0]    own_seq_reg, own_seq_next;
    logic [mge_pkg::TIME_W-1:0]   last_hb_reg, last_hb_next;

    // result register
    logic                         res_valid_reg;
    logic                         send_reg, send_next;
    logic [mge_pkg::GID_W-1:0]    sgid_reg, sgid_next;
    logic [mge_pkg::SEQ_W-1:0]    sseq_reg, sseq_next;
    logic                         srep_reg, srep_next;
    mge_pkg::status_t             status_reg, status_next;

    logic                         advance;
    logic                         take;
    logic                         addr_in_map;
    logic                         own_in_map;
    logic [IDX_W-1:0]             addr_idx;
    logic [IDX_W-1:0]             own_idx;
    logic                         addr_member;
    logic [mge_pkg::TIME_W:0]     hb_limit;
    logic                         hb_expired;
    logic [mge_pkg::GID_W-1:0]    gid_after_timeout;
    logic [mge_pkg::GID_W-1:0]    least_wide;
    logic [mge_pkg::SEQ_W-1:0]    own_seq_inc;

    // handshake: the held item moves on when the result slot frees up
    assign advance     = hold_valid_reg && (!res_valid_reg || result.ready);
    assign item.ready  = !hold_valid_reg || advance;
    assign take        = item.valid && item.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            hold_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            hold_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg    <= mge_pkg::cmd_t'(item.command);
            addr_reg   <= item.node_address;
            expiry_reg <= item.link_expiry;
            pgid_reg   <= item.packet_gid;
            pseq_reg   <= item.packet_seqno;
            now_reg    <= item.now_seconds;
        end
    end

    // member map lookups
    assign addr_in_map = CMP_W'(addr_reg) < CMP_W'(NODE_COUNT);
    assign own_in_map  = CMP_W'(cfg.own_address) < CMP_W'(NODE_COUNT);
    assign addr_idx    = addr_reg[IDX_W-1:0];
    assign own_idx     = cfg.own_address[IDX_W-1:0];
    assign addr_member = addr_in_map && member_reg[addr_idx];

    // heartbeat timeout at full precision
    assign hb_limit   = {1'b0, last_hb_reg} + (mge_pkg::TIME_W + 1)'(cfg.timeout_span);
    assign hb_expired = hb_limit < {1'b0, now_reg};
    assign least_wide = mge_pkg::GID_W'(least_reg);
    assign gid_after_timeout = hb_expired ? least_wide : gid_reg;

    // own sequence counter, wraps
    assign own_seq_inc = own_seq_reg + mge_pkg::SEQ_W'(1);

    // update logic for one item
    always_comb
    begin
        member_next  = member_reg;
        least_next   = least_reg;
        gid_next     = gid_reg;
        gseq_next    = gseq_reg;
        own_seq_next = own_seq_reg;
        last_hb_next = last_hb_reg;
        send_next    = 1'b0;
        sgid_next    = '0;
        sseq_next    = '0;
        srep_next    = 1'b0;
        status_next  = mge_pkg::ST_NONE;

        unique case (cmd_reg)
            mge_pkg::CMD_START:
            begin
                member_next = '0;
                least_next  = cfg.own_address;
            end
            mge_pkg::CMD_REPORT:
            begin
                if (expiry_reg > cfg.acceptable_expiry)
                begin
                    if (addr_in_map)
                    begin
                        member_next[addr_idx] = 1'b1;
                    end
                    if (addr_reg < least_reg)
                    begin
                        least_next = addr_reg;
                    end
                end
            end
            mge_pkg::CMD_FINISH:
            begin
                if (own_in_map)
                begin
                    member_next[own_idx] = 1'b1;
                end
                gid_next = gid_after_timeout;
                if (hb_expired)
                begin
                    last_hb_next = now_reg;
                end
                if (least_wide <= gid_after_timeout)
                begin
                    if (least_reg == cfg.own_address)
                    begin
                        own_seq_next = own_seq_inc;
                        send_next    = 1'b1;
                        sgid_next    = least_wide;
                        sseq_next    = own_seq_inc;
                    end
                    gid_next     = least_wide;
                    gseq_next    = (least_reg == cfg.own_address) ? own_seq_inc
                                                                  : own_seq_reg;
                    last_hb_next = now_reg;
                end
            end
            mge_pkg::CMD_PACKET:
            begin
                if (addr_reg == cfg.own_address)
                begin
                    status_next = mge_pkg::ST_SELF;
                end
                else if (!addr_member)
                begin
                    status_next = mge_pkg::ST_NONMEMBER;
                end
                else if (gid_reg >= pgid_reg)
                begin
                    if (gseq_reg < pseq_reg)
                    begin
                        send_next   = 1'b1;
                        sgid_next   = pgid_reg;
                        sseq_next   = pseq_reg;
                        srep_next   = 1'b1;
                        status_next = mge_pkg::ST_FORWARDED;
                    end
                    else
                    begin
                        status_next = mge_pkg::ST_TAKEN;
                    end
                    gid_next     = pgid_reg;
                    gseq_next    = pseq_reg;
                    last_hb_next = now_reg;
                end
                else
                begin
                    status_next = mge_pkg::ST_HIGHER;
                end
            end
        endcase
    end

    // state commits when the item moves into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            member_reg  <= '0;
            least_reg   <= '0;
            gid_reg     <= mge_pkg::INITIAL_GROUP_ID;
            gseq_reg    <= '0;
            own_seq_reg <= '0;
            last_hb_reg <= '0;
        end
        else if (advance)
        begin
            member_reg  <= member_next;
            least_reg   <= least_next;
            gid_reg     <= gid_next;
            gseq_reg    <= gseq_next;
            own_seq_reg <= own_seq_next;
            last_hb_reg <= last_hb_next;
        end
    end

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            send_reg   <= send_next;
            sgid_reg   <= sgid_next;
            sseq_reg   <= sseq_next;
            srep_reg   <= srep_next;
            status_reg <= status_next;
        end
    end

    assign result.valid         = res_valid_reg;
    assign result.send_valid    = send_reg;
    assign result.send_gid      = sgid_reg;
    assign result.send_seqno    = sseq_reg;
    assign result.send_repeat   = srep_reg;
    assign result.packet_status = status_reg;
    assign result.current_gid   = gid_reg;

endmodule

>>> sv/min_id_group_leader_election_top.sv
// min-id group leader election, top level
// an accepted beat passes the input register, then the result register, where it is presented
// throughput: one beat per cycle while results are taken, bounded by the single update pass in mge_core
// a waiting result holds the update; the input register then takes one more beat
// reset (rst_n low, asynchronous) clears the member map and election state,
// and loads register defaults; no clearing pass is needed after reset

module min_id_group_leader_election_top #(
    parameter int NODE_COUNT = mge_pkg::NODE_COUNT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    mge_item_if.sink                      item,
    mge_result_if.source                  result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mge_pkg::PADDR_W-1:0]   paddr,
    input  logic [mge_pkg::PDATA_W-1:0]   pwdata,
    output logic [mge_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    mge_pkg::cfg_t cfg;

    // configuration registers
    mge_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // election datapath
    mge_core #(
        .NODE_COUNT (NODE_COUNT)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .item   (item),
        .result (result)
    );

endmodule
